// ----- src/ttn_pkg.sv -----
// ttn_pkg: shared types and constants for the two-tree neighbor lookup
// no dependencies; imported by every module of the block
package ttn_pkg;

  localparam int RANK_W = 16;
  localparam int EXT_W  = RANK_W + 1;

  // neighbor slots in the per-item result vectors
  localparam int NB_PARENT = 0;
  localparam int NB_LEFT   = 1;
  localparam int NB_RIGHT  = 2;

  localparam logic [RANK_W-1:0] WORLD_SIZE_RESET = RANK_W'(2);

  // how a tree-one neighbor maps back to a real rank
  typedef enum logic [1:0] {
    MAP_NONE,
    MAP_MIRROR,
    MAP_SHIFT
  } map_t;

  typedef struct packed {
    logic [RANK_W-1:0] rank;
    logic              mode;
  } in_t;

  typedef struct packed {
    logic [RANK_W-1:0] parent_rank;
    logic              parent_valid;
    logic [RANK_W-1:0] left_rank;
    logic              left_valid;
    logic [RANK_W-1:0] right_rank;
    logic              right_valid;
  } out_t;

  // after rank mapping
  typedef struct packed {
    logic              hit;
    map_t              kind;
    logic [RANK_W-1:0] w;
    logic [RANK_W-1:0] r;
    logic [EXT_W-1:0]  wx;
  } s1_t;

  // after candidate compares
  typedef struct packed {
    logic              hit;
    map_t              kind;
    logic [RANK_W-1:0] w;
    logic [RANK_W-1:0] r;
    logic [RANK_W-1:0] lsb;
    logic [RANK_W-1:0] mask;
    logic [RANK_W-1:0] anc_ok;
    logic [RANK_W-1:0] rc_ok;
  } s2_t;

  // after neighbor selection, still in tree-one ranks
  typedef struct packed {
    logic                   hit;
    map_t                   kind;
    logic [RANK_W-1:0]      w;
    logic [2:0]             ok;
    logic [2:0][RANK_W-1:0] nb;
  } s3_t;

endpackage

// ----- src/ttn_map_in.sv -----
// ttn_map_in: first stage, range check and mapping of the rank into tree one
// depends on ttn_pkg
module ttn_map_in
  import ttn_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  in_t               item,
  input  logic [RANK_W-1:0] world_size,
  output logic              s1_valid_r,
  output s1_t               s1_r
);

  s1_t s1_nxt;

  // pick the tree and map the rank
  always_comb begin
    s1_nxt.hit = (item.rank < world_size);
    s1_nxt.w   = world_size;
    if (!item.mode) begin
      s1_nxt.kind = MAP_NONE;
      s1_nxt.r    = item.rank;
      s1_nxt.wx   = {1'b0, world_size};
    end else if (world_size[0]) begin
      s1_nxt.kind = MAP_MIRROR;
      s1_nxt.r    = (item.rank == '0) ? '0 : world_size - item.rank;
      s1_nxt.wx   = {1'b0, world_size};
    end else begin
      s1_nxt.kind = MAP_SHIFT;
      s1_nxt.r    = (item.rank == '0) ? '0 : item.rank + RANK_W'(1);
      s1_nxt.wx   = {1'b0, world_size} + EXT_W'(1);
    end
  end

  // valid bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= accept;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    s1_r <= s1_nxt;
  end

endmodule

// ----- src/ttn_cand.sv -----
// ttn_cand: second stage, compares every ancestor and right-descent candidate
// against the node count in parallel; depends on ttn_pkg
module ttn_cand
  import ttn_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic s1_valid_r,
  input  s1_t  s1_r,
  output logic s2_valid_r,
  output s2_t  s2_r
);

  s2_t s2_nxt;

  always_comb begin
    logic [EXT_W-1:0]  wm1;
    logic [RANK_W-1:0] le;
    logic [RANK_W-1:0] lt;
    logic [EXT_W-1:0]  span;
    logic [RANK_W-1:0] anc;
    logic [EXT_W-1:0]  sum;
    s2_nxt.hit  = s1_r.hit;
    s2_nxt.kind = s1_r.kind;
    s2_nxt.w    = s1_r.w;
    s2_nxt.r    = s1_r.r;
    // lowest set bit, and the bits at or below it
    s2_nxt.lsb  = s1_r.r & (~s1_r.r + RANK_W'(1));
    le          = s2_nxt.lsb ^ (s2_nxt.lsb - RANK_W'(1));
    lt          = s2_nxt.lsb - RANK_W'(1);
    // all-ones mask covering the tree height
    wm1         = s1_r.wx - EXT_W'(1);
    for (int i = 0; i < RANK_W; i++) begin
      s2_nxt.mask[i] = |(wm1 >> i);
    end
    // ancestor at level k: upper bits kept, bit k set
    for (int k = 0; k < RANK_W; k++) begin
      span = (EXT_W'(2) << k) - EXT_W'(1);
      anc  = (s1_r.r & ~span[RANK_W-1:0]) | (RANK_W'(1) << k);
      s2_nxt.anc_ok[k] = s2_nxt.mask[k] & ~le[k] & ({1'b0, anc} < s1_r.wx);
    end
    // right child then left descent: rank with one bit below the lowest set
    for (int j = 0; j < RANK_W; j++) begin
      sum = {1'b0, s1_r.r} + (EXT_W'(1) << j);
      s2_nxt.rc_ok[j] = lt[j] & (sum < s1_r.wx);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s2_r <= s2_nxt;
  end

endmodule

// ----- src/ttn_select.sv -----
// ttn_select: third stage, priority picks of parent and right child, left child
// depends on ttn_pkg
module ttn_select
  import ttn_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic s2_valid_r,
  input  s2_t  s2_r,
  output logic s3_valid_r,
  output s3_t  s3_r
);

  s3_t s3_nxt;

  always_comb begin
    logic              root;
    logic              leaf;
    logic [EXT_W-1:0]  span;
    s3_nxt.hit  = s2_r.hit;
    s3_nxt.kind = s2_r.kind;
    s3_nxt.w    = s2_r.w;
    root        = (s2_r.r == '0);
    leaf        = s2_r.lsb[0];
    s3_nxt.ok   = '0;
    s3_nxt.nb   = '0;

    // parent: lowest ancestor in range, the root otherwise
    s3_nxt.ok[NB_PARENT] = !root;
    for (int k = RANK_W - 1; k >= 0; k--) begin
      span = (EXT_W'(2) << k) - EXT_W'(1);
      if (s2_r.anc_ok[k]) begin
        s3_nxt.nb[NB_PARENT] = (s2_r.r & ~span[RANK_W-1:0]) | (RANK_W'(1) << k);
      end
    end
    if (root) begin
      s3_nxt.nb[NB_PARENT] = '0;
    end

    // left child
    if (leaf) begin
      s3_nxt.ok[NB_LEFT] = 1'b0;
    end else if (root) begin
      s3_nxt.ok[NB_LEFT] = (s2_r.mask != '0);
      s3_nxt.nb[NB_LEFT] = s2_r.mask ^ (s2_r.mask >> 1);
    end else begin
      s3_nxt.ok[NB_LEFT] = 1'b1;
      s3_nxt.nb[NB_LEFT] = (s2_r.r & ~s2_r.lsb) | (s2_r.lsb >> 1);
    end

    // right child: deepest-first descent, highest in-range candidate wins
    for (int j = 0; j < RANK_W; j++) begin
      if (s2_r.rc_ok[j]) begin
        s3_nxt.ok[NB_RIGHT] = 1'b1;
        s3_nxt.nb[NB_RIGHT] = s2_r.r | (RANK_W'(1) << j);
      end
    end
    if (root || leaf) begin
      s3_nxt.ok[NB_RIGHT] = 1'b0;
      s3_nxt.nb[NB_RIGHT] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else begin
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s3_r <= s3_nxt;
  end

endmodule

// ----- src/ttn_map_out.sv -----
// ttn_map_out: last stage, maps neighbors back to real ranks, output register
// depends on ttn_pkg
module ttn_map_out
  import ttn_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic s3_valid_r,
  input  s3_t  s3_r,
  output logic out_strobe_r,
  output out_t out_item_r
);

  out_t                   out_item_nxt;
  logic [2:0]             ok;
  logic [2:0][RANK_W-1:0] rk;

  // per-neighbor map back
  always_comb begin
    for (int n = 0; n < 3; n++) begin
      ok[n] = s3_r.hit & s3_r.ok[n];
      case (s3_r.kind)
        MAP_NONE:   rk[n] = s3_r.nb[n];
        MAP_MIRROR: rk[n] = (s3_r.nb[n] == '0) ? '0 : s3_r.w - s3_r.nb[n];
        MAP_SHIFT:  rk[n] = (s3_r.nb[n] == '0) ? '0 : s3_r.nb[n] - RANK_W'(1);
        default:    rk[n] = '0;
      endcase
      if (!ok[n]) begin
        rk[n] = '0;
      end
    end
    out_item_nxt.parent_rank  = rk[NB_PARENT];
    out_item_nxt.parent_valid = ok[NB_PARENT];
    out_item_nxt.left_rank    = rk[NB_LEFT];
    out_item_nxt.left_valid   = ok[NB_LEFT];
    out_item_nxt.right_rank   = rk[NB_RIGHT];
    out_item_nxt.right_valid  = ok[NB_RIGHT];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= s3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

endmodule

// ----- src/two_tree_neighbour_calc.sv -----
// two_tree_neighbour_calc: top level of the two-tree neighbor lookup
// depends on ttn_pkg, ttn_map_in, ttn_cand, ttn_select, ttn_map_out
//
//   channel  ports                        handshake
//   input    start, busy, in_item         taken when start && !busy
//   result   out_strobe, out_item         one cycle, taken at its closing edge
//   config   cfg_we, cfg_wdata            world_size written when cfg_we
//
// Four register stages: map, candidate compare, select, map back.
// An item taken at one edge passes the map, candidate, select and map-back registers
// in turn before it shows on out_strobe; one item per cycle, busy stays low.
// Synchronous active-low reset clears the stage valid bits and sets
// world_size to 2. The receiver cannot stall, so nothing holds the pipeline.
module two_tree_neighbour_calc
  import ttn_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  in_t               in_item,
  input  logic              cfg_we,
  input  logic [RANK_W-1:0] cfg_wdata,
  output logic              out_strobe,
  output out_t              out_item
);

  logic [RANK_W-1:0] world_size_r;
  logic              accept;
  logic              s1_valid_r;
  s1_t               s1_r;
  logic              s2_valid_r;
  s2_t               s2_r;
  logic              s3_valid_r;
  s3_t               s3_r;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // node count register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      world_size_r <= WORLD_SIZE_RESET;
    end else if (cfg_we) begin
      world_size_r <= cfg_wdata;
    end
  end

  ttn_map_in u_map_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .item       (in_item),
    .world_size (world_size_r),
    .s1_valid_r (s1_valid_r),
    .s1_r       (s1_r)
  );

  ttn_cand u_cand (
    .clk        (clk),
    .rst_n      (rst_n),
    .s1_valid_r (s1_valid_r),
    .s1_r       (s1_r),
    .s2_valid_r (s2_valid_r),
    .s2_r       (s2_r)
  );

  ttn_select u_select (
    .clk        (clk),
    .rst_n      (rst_n),
    .s2_valid_r (s2_valid_r),
    .s2_r       (s2_r),
    .s3_valid_r (s3_valid_r),
    .s3_r       (s3_r)
  );

  ttn_map_out u_map_out (
    .clk          (clk),
    .rst_n        (rst_n),
    .s3_valid_r   (s3_valid_r),
    .s3_r         (s3_r),
    .out_strobe_r (out_strobe),
    .out_item_r   (out_item)
  );

  // every taken item comes out on out_strobe
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##4 out_strobe)
    else $error("item lost in pipeline");

  // absent neighbors carry a zero rank
  a_zero_absent: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> ((out_item.parent_valid || out_item.parent_rank == '0) &&
                    (out_item.left_valid || out_item.left_rank == '0) &&
                    (out_item.right_valid || out_item.right_rank == '0)))
    else $error("absent neighbor with nonzero rank");

  // a right child implies a left child
  a_right_has_left: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_item.right_valid) |-> out_item.left_valid)
    else $error("right child without left child");

endmodule

// ----- tb/ttn_checker.sv -----
// ttn_checker: watches the lookup, result and world_size channels of the
// two-tree neighbor lookup, predicts each result and compares it field by field
// depends on ttn_pkg only
`timescale 1ns / 100ps

module ttn_checker
  import ttn_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              busy,
  input  in_t               in_item,
  input  logic              cfg_we,
  input  logic [RANK_W-1:0] cfg_wdata,
  input  logic              out_strobe,
  input  out_t              out_item,
  output int                fails,
  output int                pending
);

  // one accepted item with the neighbors it should produce
  typedef struct {
    logic [RANK_W-1:0] rank;
    logic              mode;
    out_t              nbrs;
  } lookup_t;

  lookup_t           nbr_queue[$];
  logic [RANK_W-1:0] world_size_q;

  task automatic report_mismatch(input string what);
    $display("ERROR at %0t: %s", $time, what);
    fails++;
  endtask

  // in-order tree from the lowest set bit, node r of w nodes
  function automatic void inorder_tree(input bit [31:0] r, input bit [31:0] w,
                                       output bit [2:0][31:0] nb, output bit [2:0] ok);
    int unsigned b;
    int          i;
    bit [31:0]   mask;
    bit [31:0]   lsb;
    bit [31:0]   x;
    bit [31:0]   lx;
    bit          alive;
    b = 0;
    while (b < 31 && (32'd1 << b) < w) b++;
    mask = (32'd1 << b) - 32'd1;
    lsb  = r & (~r + 32'd1);
    nb   = '0;
    ok   = '0;
    // parent: move lowest set bit up, climb while out of range
    if (r != 0) begin
      x = ((r & ~lsb) | (lsb << 1)) & mask;
      for (i = 0; i <= RANK_W + 2 && x >= w && x != 0; i++) begin
        lx = x & (~x + 32'd1);
        x  = ((x & ~lx) | (lx << 1)) & mask;
      end
      ok[NB_PARENT] = 1'b1;
      nb[NB_PARENT] = x;
    end
    // left child: move lowest set bit down; root takes the top bit
    if (lsb != 32'd1) begin
      if (r == 0) begin
        if (b >= 1) begin
          ok[NB_LEFT] = 1'b1;
          nb[NB_LEFT] = 32'd1 << (b - 1);
        end
      end else begin
        ok[NB_LEFT] = 1'b1;
        nb[NB_LEFT] = (r & ~lsb) | (lsb >> 1);
      end
    end
    // right child: descend left while out of range, give up at a leaf
    if (lsb != 32'd1 && r != 0) begin
      alive = 1'b1;
      x     = r | (lsb >> 1);
      for (i = 0; i <= RANK_W + 2 && alive && x >= w; i++) begin
        lx = x & (~x + 32'd1);
        if (lx <= 32'd1) alive = 1'b0;
        else x = (x & ~lx) | (lx >> 1);
      end
      if (alive && x < w) begin
        ok[NB_RIGHT] = 1'b1;
        nb[NB_RIGHT] = x;
      end
    end
  endfunction

  // full lookup in either tree, out-of-range ranks give nothing
  function automatic out_t tree_neighbours(input bit [RANK_W-1:0] rank, input bit mode,
                                           input bit [RANK_W-1:0] wsz);
    bit [31:0]        w;
    bit [31:0]        r;
    bit [2:0][31:0]   nb;
    bit [2:0]         ok;
    out_t             res;
    int               k;
    w  = 32'(wsz);
    r  = 32'(rank);
    nb = '0;
    ok = '0;
    if (r < w) begin
      if (!mode) begin
        inorder_tree(r, w, nb, ok);
      end else if (w[0]) begin
        // odd size: mirrored ranks
        inorder_tree((r == 0) ? 32'd0 : w - r, w, nb, ok);
        for (k = 0; k < 3; k++)
          if (ok[k]) nb[k] = (nb[k] == 0) ? 32'd0 : w - nb[k];
      end else begin
        // even size: shifted by one over w+1 nodes
        inorder_tree((r == 0) ? 32'd0 : r + 32'd1, w + 32'd1, nb, ok);
        for (k = 0; k < 3; k++)
          if (ok[k] && nb[k] != 0) nb[k] = nb[k] - 32'd1;
      end
    end
    res.parent_rank  = ok[NB_PARENT] ? nb[NB_PARENT][RANK_W-1:0] : '0;
    res.parent_valid = ok[NB_PARENT];
    res.left_rank    = ok[NB_LEFT] ? nb[NB_LEFT][RANK_W-1:0] : '0;
    res.left_valid   = ok[NB_LEFT];
    res.right_rank   = ok[NB_RIGHT] ? nb[NB_RIGHT][RANK_W-1:0] : '0;
    res.right_valid  = ok[NB_RIGHT];
    return res;
  endfunction

  task automatic check_field(input string name, input lookup_t lk,
                             input logic [RANK_W-1:0] got, input logic [RANK_W-1:0] exp);
    if (got !== exp)
      report_mismatch($sformatf("rank %0d tree %0d w %0d: %s got %0d expected %0d",
                                lk.rank, lk.mode, world_size_q, name, got, exp));
  endtask

  // sample all channels at the edge that takes them
  always @(posedge clk) begin
    lookup_t lk;
    if (!rst_n) begin
      world_size_q = WORLD_SIZE_RESET;
      fails        = 0;
      nbr_queue.delete();
    end else begin
      if (out_strobe) begin
        if (nbr_queue.size() == 0) begin
          report_mismatch("result with no lookup outstanding");
        end else begin
          lk = nbr_queue.pop_front();
          check_field("parent_rank", lk, out_item.parent_rank, lk.nbrs.parent_rank);
          check_field("parent_valid", lk, RANK_W'(out_item.parent_valid),
                      RANK_W'(lk.nbrs.parent_valid));
          check_field("left_rank", lk, out_item.left_rank, lk.nbrs.left_rank);
          check_field("left_valid", lk, RANK_W'(out_item.left_valid),
                      RANK_W'(lk.nbrs.left_valid));
          check_field("right_rank", lk, out_item.right_rank, lk.nbrs.right_rank);
          check_field("right_valid", lk, RANK_W'(out_item.right_valid),
                      RANK_W'(lk.nbrs.right_valid));
        end
      end
      // an item taken at this edge still sees the old node count
      if (start && !busy) begin
        lk.rank = in_item.rank;
        lk.mode = in_item.mode;
        lk.nbrs = tree_neighbours(in_item.rank, in_item.mode, world_size_q);
        nbr_queue.push_back(lk);
      end
      if (cfg_we) world_size_q = cfg_wdata;
    end
    pending <= nbr_queue.size();
  end

endmodule

// ----- tb/tb_two_tree_neighbour_calc.sv -----
// tb_two_tree_neighbour_calc: drives lookups and world_size writes into the
// two-tree neighbor lookup; depends on ttn_pkg, two_tree_neighbour_calc, ttn_checker
`timescale 1ns / 100ps

module tb_two_tree_neighbour_calc;
  import ttn_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 8;
  localparam int N_PHASES     = 24;
  localparam int PHASE_ITEMS  = 35;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              start;
  logic              busy;
  in_t               in_item;
  logic              cfg_we;
  logic [RANK_W-1:0] cfg_wdata;
  logic              out_strobe;
  out_t              out_item;
  int                fails;
  int                pending;

  int                cycle_count = 0;
  int                n_sent = 0;
  int                n_sizes = 0;
  bit                no_gaps = 1'b0;

  // sizes around powers of two and both extremes
  int unsigned fixed_sizes [16] = '{2, 3, 4, 5, 7, 8, 9, 16, 17, 100, 255, 256,
                                    4096, 32769, 65534, 65535};

  always #1 clk = ~clk;

  two_tree_neighbour_calc u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

  ttn_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .out_strobe (out_strobe),
    .out_item   (out_item),
    .fails      (fails),
    .pending    (pending)
  );

  // hold off until every outstanding lookup has returned
  task automatic wait_for_results();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic set_world_size(input logic [RANK_W-1:0] w);
    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= w;
    @(posedge clk);
    cfg_we    <= 1'b0;
    n_sizes++;
  endtask

  // one lookup item, with a random gap in front unless gaps are off
  task automatic send_lookup(input logic [RANK_W-1:0] r, input logic m);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_item <= '{rank: r, mode: m};
    @(posedge clk);
    while (busy) @(posedge clk);
    n_sent++;
  endtask

  // mostly in-range ranks, some at the edge and some anywhere
  function automatic logic [RANK_W-1:0] pick_rank(input int unsigned w);
    int unsigned sel;
    sel = $urandom_range(0, 19);
    if (sel < 16) return RANK_W'($urandom_range(0, w - 1));
    if (sel < 18) return RANK_W'(w - 1 - $urandom_range(0, (w > 4) ? 3 : w - 1));
    if (sel == 18) return RANK_W'(w);
    return RANK_W'($urandom_range(0, 65535));
  endfunction

  // run time limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_two_tree_neighbour_calc NOT OK");
      $finish;
    end
  end

  initial begin
    int unsigned w;
    int          p;
    int          i;
    rst_n     <= 1'b0;
    start     <= 1'b0;
    in_item   <= '0;
    cfg_we    <= 1'b0;
    cfg_wdata <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed: reset size of two, both trees, out-of-range ranks
    send_lookup(16'd0, 1'b0);
    send_lookup(16'd0, 1'b1);
    send_lookup(16'd1, 1'b0);
    send_lookup(16'd1, 1'b1);
    send_lookup(16'd2, 1'b0);
    send_lookup(16'hFFFF, 1'b1);
    // even size that is not a power of two: climbing parent, descending right
    set_world_size(16'd12);
    send_lookup(16'd0, 1'b0);
    send_lookup(16'd0, 1'b1);
    send_lookup(16'd8, 1'b0);
    send_lookup(16'd10, 1'b0);
    send_lookup(16'd6, 1'b1);
    send_lookup(16'd11, 1'b1);
    send_lookup(16'd12, 1'b0);
    // odd size: mirrored tree two
    set_world_size(16'd13);
    send_lookup(16'd1, 1'b1);
    send_lookup(16'd12, 1'b1);
    send_lookup(16'd6, 1'b1);
    // largest size
    set_world_size(16'hFFFF);
    send_lookup(16'hFFFE, 1'b0);
    send_lookup(16'h8000, 1'b1);
    send_lookup(16'd0, 1'b1);
    // degenerate sizes with no neighbors
    set_world_size(16'd1);
    send_lookup(16'd0, 1'b0);
    send_lookup(16'd0, 1'b1);
    set_world_size(16'd0);
    send_lookup(16'd0, 1'b0);
    // largest even size: shifted tree over one more node
    set_world_size(16'hFFFE);
    send_lookup(16'hFFFD, 1'b1);

    // random phases over many sizes
    for (p = 0; p < N_PHASES; p++) begin
      if (p < 16) w = fixed_sizes[p];
      else if (p % 2 == 1) w = $urandom_range(2, 64);
      else w = $urandom_range(2, 65535);
      set_world_size(RANK_W'(w));
      no_gaps = (p % 4 == 3);
      for (i = 0; i < PHASE_ITEMS; i++) begin
        if ((p == 0 && i == PHASE_ITEMS / 2) || $urandom_range(0, 59) == 0)
          wait_for_results();
        send_lookup(pick_rank(w), 1'($urandom_range(0, 1)));
      end
    end

    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d lookups in both trees over %0d world sizes,", n_sent, n_sizes);
    $display("from the degenerate sizes up to 65535, with and without sender gaps");
    if (fails == 0) begin
      $display("tb_two_tree_neighbour_calc OK");
    end else begin
      $display("tb_two_tree_neighbour_calc NOT OK");
    end
    $finish;
  end

endmodule

// ----- two_tree_neighbour_calc.f -----
src/ttn_pkg.sv
src/ttn_map_in.sv
src/ttn_cand.sv
src/ttn_select.sv
src/ttn_map_out.sv
src/two_tree_neighbour_calc.sv
tb/ttn_checker.sv
tb/tb_two_tree_neighbour_calc.sv
